// ----- design/gmsvc_pkg.sv -----
package gmsvc_pkg;

    // One stored word: load order, saturated vowel count, odd length
    typedef struct packed {
        logic [5:0] index;
        logic [7:0] vowels;
        logic       odd;
    } rec_t;

    // Record write from the loader
    typedef struct packed {
        logic en;
        rec_t rec;
    } ld_wr_t;

    localparam logic [7:0] VOWEL_MAX = 8'd255;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_CALL,
        ST_GATE,
        ST_RET,
        ST_MRD,
        ST_MCMP,
        ST_CRD,
        ST_CWR,
        ST_ORD,
        ST_OSHOW,
        ST_OWAIT
    } state_t;

    function automatic logic is_vowel(input logic [7:0] c);
        logic v;
        v = 1'b0;
        case (c) inside
            "A", "E", "I", "O", "U", "Y", "a", "e", "i", "o", "u", "y": v = 1'b1;
            default: v = 1'b0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/gmsvc_if.sv -----
interface gmsvc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       word_end;
    logic       list_end;

    modport source (output valid, char_code, word_end, list_end, input ready);
    modport sink (input valid, char_code, word_end, list_end, output ready);
endinterface

interface gmsvc_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] word_index;
    logic [7:0] vowel_count;
    logic       last;
    logic       no_words;
    logic       overflow;

    modport source (output valid, word_index, vowel_count, last, no_words, overflow,
                    input ready);
    modport sink (input valid, word_index, vowel_count, last, no_words, overflow,
                  output ready);
endinterface

// ----- design/gmsvc_ram.sv -----
module gmsvc_ram
    import gmsvc_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  rec_t          wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output rec_t          rdata_a,
    output rec_t          rdata_b
);

    rec_t mem [DEPTH];

    // Write one record, read two with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- design/gmsvc_loader.sv -----
module gmsvc_loader
    import gmsvc_pkg::*;
#(
    parameter int MAX_WORDS = 32,
    parameter int IW        = 5,
    parameter int CW        = 6
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic [7:0]    char_code,
    input  logic          word_end,
    input  logic          list_end,
    input  logic          clr,
    output ld_wr_t        wr,
    output logic [IW-1:0] wr_addr,
    output logic [CW-1:0] count,
    output logic          dropped
);

    logic [7:0]    vow_reg, vow_next;
    logic          odd_reg, odd_next;
    logic          any_reg, any_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          drop_reg, drop_next;

    // Count the character and close the word on a word or list end
    always_comb
    begin
        vow_next      = vow_reg;
        odd_next      = odd_reg;
        any_next      = any_reg;
        cnt_next      = cnt_reg;
        drop_next     = drop_reg;
        wr.en         = 1'b0;
        wr.rec.index  = 6'(cnt_reg);
        wr.rec.vowels = vow_reg;
        wr.rec.odd    = odd_reg;
        if (take)
        begin
            if (char_code != 8'd0)
            begin
                any_next = 1'b1;
                odd_next = ~odd_reg;
                if (is_vowel(char_code) && (vow_reg != VOWEL_MAX))
                begin
                    vow_next = vow_reg + 8'd1;
                end
            end
            // Capture the closing word before its counters are cleared
            wr.rec.vowels = vow_next;
            wr.rec.odd    = odd_next;
            if (word_end || list_end)
            begin
                if (any_next)
                begin
                    if (cnt_reg < CW'(MAX_WORDS))
                    begin
                        wr.en    = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
                vow_next = 8'd0;
                odd_next = 1'b0;
                any_next = 1'b0;
            end
        end
        if (clr)
        begin
            cnt_next  = '0;
            drop_next = 1'b0;
        end
    end

    assign wr_addr       = cnt_reg[IW-1:0];
    assign count         = cnt_reg;
    assign dropped       = drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vow_reg  <= '0;
            odd_reg  <= 1'b0;
            any_reg  <= 1'b0;
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            vow_reg  <= vow_next;
            odd_reg  <= odd_next;
            any_reg  <= any_next;
            cnt_reg  <= cnt_next;
            drop_reg <= drop_next;
        end
    end

endmodule

// ----- design/gated_merge_sort_by_vowel_count.sv -----
// Loads words one character per cycle (items always ready while loading) and
// keeps per word its load index, saturated vowel count and length parity. On
// the word carrying list_end the block stops taking words and runs a top-down
// stable merge sort through a small range stack, splitting a range only when
// the record at its start has odd length. Each range call fetches and tests its
// first record; each merged element passes through the shared compare unit into
// the merge buffer and is then copied back, all bound by the single write port
// of the record RAM. Results then leave one word at a time, the next only after
// the previous one is taken; an empty list gives one result flagged no_words.
// Loading resumes after the last result is taken.
module gated_merge_sort_by_vowel_count
    import gmsvc_pkg::*;
#(
    parameter int MAX_WORDS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    gmsvc_in_if.sink    items,
    gmsvc_out_if.source results
);

    localparam int IW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW  = $clog2(MAX_WORDS + 1);
    localparam int SD  = IW + 1;
    localparam int SIW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);

    state_t state_reg, state_next;

    logic [IW-1:0]  lo_reg, lo_next;
    logic [IW-1:0]  hi_reg, hi_next;
    logic [IW-1:0]  mid_reg, mid_next;
    logic [IW:0]    a_reg, a_next;
    logic [IW:0]    b_reg, b_next;
    logic [IW-1:0]  m_reg, m_next;
    logic [IW-1:0]  i_reg, i_next;
    logic [IW-1:0]  k_reg, k_next;
    logic [SPW-1:0] sp_reg, sp_next;

    logic       ov_reg, ov_next;
    logic [5:0] oidx_reg, oidx_next;
    logic [7:0] ovow_reg, ovow_next;
    logic       olast_reg, olast_next;
    logic       onone_reg, onone_next;
    logic       oflow_reg, oflow_next;

    // Range stack: lo, hi, and whether the merge is due (else the right half)
    logic [IW-1:0] stk_lo [SD];
    logic [IW-1:0] stk_hi [SD];
    logic          stk_ph [SD];
    logic           stk_we;
    logic [SIW-1:0] stk_wa;
    logic [IW-1:0]  stk_wlo, stk_whi;
    logic           stk_wph;
    logic [SIW-1:0] top;

    // Merge buffer
    rec_t          buf_mem [MAX_WORDS];
    rec_t          buf_rd_reg;
    logic          buf_we;
    rec_t          buf_wd;

    // Record RAM ports
    logic          ram_we;
    logic [IW-1:0] ram_wa;
    rec_t          ram_wd;
    logic [IW-1:0] ram_ra, ram_rb;
    rec_t          rd_a, rd_b;

    // Loader
    logic          take;
    logic          clr;
    ld_wr_t        ld_wr;
    logic [IW-1:0] ld_addr;
    logic [CW-1:0] count;
    logic          dropped;

    logic [IW:0]   mid_sum, fmid_sum;
    logic [IW-1:0] mid_cur, mid_top;
    logic          a_ok, b_ok, take_a;
    rec_t          pick;
    logic [IW-1:0] span;
    logic [IW:0]   wb_sum;

    assign items.ready = (state_reg == ST_LOAD);
    assign take        = items.valid && items.ready;

    gmsvc_loader #(
        .MAX_WORDS (MAX_WORDS),
        .IW        (IW),
        .CW        (CW)
    ) u_loader (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .char_code (items.char_code),
        .word_end  (items.word_end),
        .list_end  (items.list_end),
        .clr       (clr),
        .wr        (ld_wr),
        .wr_addr   (ld_addr),
        .count     (count),
        .dropped   (dropped)
    );

    gmsvc_ram #(
        .DEPTH (MAX_WORDS),
        .AW    (IW)
    ) u_records (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_wa),
        .wdata   (ram_wd),
        .raddr_a (ram_ra),
        .raddr_b (ram_rb),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // Midpoints of the current range and of the stack top
    assign top      = SIW'(sp_reg - 1'b1);
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_cur  = mid_sum[IW:1];
    assign fmid_sum = {1'b0, stk_lo[top]} + {1'b0, stk_hi[top]};
    assign mid_top  = fmid_sum[IW:1];

    // Shared compare: pick the next record of the merge
    assign a_ok   = a_reg <= {1'b0, mid_reg};
    assign b_ok   = b_reg <= {1'b0, hi_reg};
    assign take_a = a_ok && (!b_ok || (rd_a.vowels <= rd_b.vowels));
    assign pick   = take_a ? rd_a : rd_b;
    assign span   = hi_reg - lo_reg;
    assign wb_sum = {1'b0, lo_reg} + {1'b0, i_reg};

    // Record RAM access
    always_comb
    begin
        ram_we = 1'b0;
        ram_wa = ld_addr;
        ram_wd = ld_wr.rec;
        if (state_reg == ST_LOAD)
        begin
            ram_we = ld_wr.en;
        end
        else if (state_reg == ST_CWR)
        begin
            ram_we = 1'b1;
            ram_wa = wb_sum[IW-1:0];
            ram_wd = buf_rd_reg;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_MRD:  ram_ra = a_reg[IW-1:0];
            ST_ORD:  ram_ra = k_reg;
            default: ram_ra = lo_reg;
        endcase
    end
    assign ram_rb = b_reg[IW-1:0];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        m_next     = m_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        sp_next    = sp_reg;
        ov_next    = ov_reg;
        oidx_next  = oidx_reg;
        ovow_next  = ovow_reg;
        olast_next = olast_reg;
        onone_next = onone_reg;
        oflow_next = oflow_reg;
        stk_we     = 1'b0;
        stk_wa     = SIW'(sp_reg);
        stk_wlo    = lo_reg;
        stk_whi    = hi_reg;
        stk_wph    = 1'b0;
        buf_we     = 1'b0;
        buf_wd     = pick;
        clr        = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (take && items.list_end)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (count == '0)
                begin
                    oidx_next  = '0;
                    ovow_next  = '0;
                    olast_next = 1'b1;
                    onone_next = 1'b1;
                    oflow_next = dropped;
                    ov_next    = 1'b1;
                    state_next = ST_OWAIT;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = IW'(count - 1'b1);
                    sp_next    = '0;
                    state_next = ST_CALL;
                end
            end
            ST_CALL:
            begin
                state_next = ST_GATE;
            end
            ST_GATE:
            begin
                if (rd_a.odd && (lo_reg < hi_reg))
                begin
                    stk_we     = 1'b1;
                    sp_next    = sp_reg + 1'b1;
                    hi_next    = mid_cur;
                    state_next = ST_CALL;
                end
                else
                begin
                    state_next = ST_RET;
                end
            end
            ST_RET:
            begin
                if (sp_reg == '0)
                begin
                    k_next     = '0;
                    state_next = ST_ORD;
                end
                else if (!stk_ph[top])
                begin
                    // Left half done: mark merge due, descend into right half
                    stk_we     = 1'b1;
                    stk_wa     = top;
                    stk_wlo    = stk_lo[top];
                    stk_whi    = stk_hi[top];
                    stk_wph    = 1'b1;
                    lo_next    = mid_top + 1'b1;
                    hi_next    = stk_hi[top];
                    state_next = ST_CALL;
                end
                else
                begin
                    // Both halves done: pop and merge
                    sp_next    = sp_reg - 1'b1;
                    lo_next    = stk_lo[top];
                    hi_next    = stk_hi[top];
                    mid_next   = mid_top;
                    a_next     = {1'b0, stk_lo[top]};
                    b_next     = {1'b0, mid_top} + 1'b1;
                    m_next     = '0;
                    state_next = ST_MRD;
                end
            end
            ST_MRD:
            begin
                state_next = ST_MCMP;
            end
            ST_MCMP:
            begin
                buf_we = 1'b1;
                if (take_a)
                begin
                    a_next = a_reg + 1'b1;
                end
                else
                begin
                    b_next = b_reg + 1'b1;
                end
                m_next = m_reg + 1'b1;
                if (m_reg == span)
                begin
                    i_next     = '0;
                    state_next = ST_CRD;
                end
                else
                begin
                    state_next = ST_MRD;
                end
            end
            ST_CRD:
            begin
                state_next = ST_CWR;
            end
            ST_CWR:
            begin
                if (i_reg == span)
                begin
                    state_next = ST_RET;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_CRD;
                end
            end
            ST_ORD:
            begin
                state_next = ST_OSHOW;
            end
            ST_OSHOW:
            begin
                oidx_next  = rd_a.index;
                ovow_next  = rd_a.vowels;
                olast_next = ((CW'(k_reg) + 1'b1) == count);
                onone_next = 1'b0;
                oflow_next = dropped;
                ov_next    = 1'b1;
                state_next = ST_OWAIT;
            end
            ST_OWAIT:
            begin
                if (results.ready)
                begin
                    ov_next = 1'b0;
                    if (olast_reg)
                    begin
                        clr        = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_ORD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Hold stack frames and the merge buffer
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_lo[stk_wa] <= stk_wlo;
            stk_hi[stk_wa] <= stk_whi;
            stk_ph[stk_wa] <= stk_wph;
        end
        if (buf_we)
        begin
            buf_mem[m_reg] <= buf_wd;
        end
        buf_rd_reg <= buf_mem[i_reg];
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            sp_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            ov_reg    <= ov_next;
        end
    end

    // Hold pointers and the result word
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        m_reg     <= m_next;
        i_reg     <= i_next;
        k_reg     <= k_next;
        oidx_reg  <= oidx_next;
        ovow_reg  <= ovow_next;
        olast_reg <= olast_next;
        onone_reg <= onone_next;
        oflow_reg <= oflow_next;
    end

    assign results.valid       = ov_reg;
    assign results.word_index  = oidx_reg;
    assign results.vowel_count = ovow_reg;
    assign results.last        = olast_reg;
    assign results.no_words    = onone_reg;
    assign results.overflow    = oflow_reg;

endmodule
